/* rtl/core/prc_pkg.sv */
// ----------------------------------------------------------------------------
// prc_pkg
// Shared types and constants of the polygon rectangle clipper.
// ----------------------------------------------------------------------------
package prc_pkg;

	localparam int COORD_W = 24;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_LEFT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TOP    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BOTTOM = 3'd3;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		coord_t vertex_x;
		coord_t vertex_y;
		logic   last_vertex;
	} in_item_t;

	typedef struct packed {
		coord_t out_x;
		coord_t out_y;
		logic   out_last;
		logic   empty_res;
		logic   overflow;
	} out_item_t;

	// vertex stream between cells; eop closes a polygon and may carry no vertex
	typedef struct packed {
		coord_t x;
		coord_t y;
		logic   has_vtx;
		logic   eop;
		logic   ovf;
	} token_t;

endpackage

/* rtl/core/prc_clip_cell.sv */
// ----------------------------------------------------------------------------
// prc_clip_cell
// One clip pass against a single boundary: buffers a polygon, then walks it.
// ----------------------------------------------------------------------------
module prc_clip_cell #(
	parameter int DEPTH = 16,
	parameter int MAXS = 16,
	parameter bit ON_Y = 1'b0,
	parameter bit KEEP_GE = 1'b1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  prc_pkg::coord_t edge_val,
	input  logic            in_valid,
	output logic            in_ready,
	input  prc_pkg::token_t in_tok,
	output logic            out_valid,
	input  logic            out_ready,
	output prc_pkg::token_t out_tok
);

	localparam int CW = prc_pkg::COORD_W;
	localparam int AW = $clog2(DEPTH);
	localparam int CNTW = $clog2(DEPTH + 1);
	localparam int OCW = $clog2(MAXS + 1);
	localparam int PW = 2 * (CW + 1);
	localparam int SW = $clog2(PW + 1);
	localparam logic [CNTW-1:0] DEPTH_C = CNTW'(DEPTH);
	localparam logic [OCW-1:0] MAXS_C = OCW'(MAXS);
	localparam logic [SW-1:0] LAST_STEP_C = SW'(PW - 1);
	localparam logic signed [PW+1:0] CMAX = (PW+2)'((64'sd1 <<< (CW - 1)) - 64'sd1);
	localparam logic signed [PW+1:0] CMIN = -CMAX - (PW+2)'(1);

	localparam logic [3:0] S_COLL  = 4'd0;
	localparam logic [3:0] S_RPREV = 4'd1;
	localparam logic [3:0] S_LPREV = 4'd2;
	localparam logic [3:0] S_EVAL  = 4'd3;
	localparam logic [3:0] S_MUL   = 4'd4;
	localparam logic [3:0] S_DIV   = 4'd5;
	localparam logic [3:0] S_FIN   = 4'd6;
	localparam logic [3:0] S_EMITX = 4'd7;
	localparam logic [3:0] S_EMITC = 4'd8;
	localparam logic [3:0] S_ADV   = 4'd9;
	localparam logic [3:0] S_WAIT  = 4'd10;
	localparam logic [3:0] S_END   = 4'd11;

	logic [3:0]      state_q;
	logic [CNTW-1:0] cnt_q, idx_q, cnt_n;
	logic [OCW-1:0]  ocnt_q;
	logic            ovf_q;
	logic [2*CW-1:0] mem [DEPTH];
	logic [2*CW-1:0] rdata_q;
	prc_pkg::coord_t prev_x_q, prev_y_q, cur_x_q, cur_y_q, cross_q;
	logic            cin_q, neg_q;
	logic [CW:0]     mag_a_q, mag_b_q, mag_c_q;
	logic [PW-1:0]   prod_q;
	logic [CW:0]     rem_q;
	logic [SW-1:0]   step_q;

	prc_pkg::coord_t rd_x, rd_y, pa, ca, po, co, coc;
	logic            pin, cin, wr_en, room, full_out;
	logic signed [CW:0] da, db, dc;
	logic [CW+1:0]   rem_sh;
	logic            qbit;
	logic signed [PW+1:0] qs, sum;
	prc_pkg::coord_t clamped;

	assign rd_x = rdata_q[2*CW-1:CW];
	assign rd_y = rdata_q[CW-1:0];
	assign pa = ON_Y ? prev_y_q : prev_x_q;
	assign po = ON_Y ? prev_x_q : prev_y_q;
	assign ca = ON_Y ? rd_y : rd_x;
	assign co = ON_Y ? rd_x : rd_y;
	assign coc = ON_Y ? cur_x_q : cur_y_q;
	assign pin = KEEP_GE ? (pa >= edge_val) : (pa < edge_val);
	assign cin = KEEP_GE ? (ca >= edge_val) : (ca < edge_val);
	assign da = {po[CW-1], po} - {co[CW-1], co};
	assign db = {edge_val[CW-1], edge_val} - {ca[CW-1], ca};
	assign dc = {pa[CW-1], pa} - {ca[CW-1], ca};

	// restoring divide, quotient bits shift into the product register
	assign rem_sh = {rem_q, prod_q[PW-1]};
	assign qbit = rem_sh >= {1'b0, mag_c_q};

	assign qs = neg_q ? -$signed({2'b00, prod_q}) : $signed({2'b00, prod_q});
	assign sum = qs + {{(PW+2-CW){coc[CW-1]}}, coc};
	always_comb begin
		if (sum > CMAX) begin
			clamped = CMAX[CW-1:0];
		end else if (sum < CMIN) begin
			clamped = CMIN[CW-1:0];
		end else begin
			clamped = sum[CW-1:0];
		end
	end

	assign room = cnt_q < DEPTH_C;
	assign wr_en = (state_q == S_COLL) && in_valid && in_tok.has_vtx && room;
	assign cnt_n = cnt_q + CNTW'(wr_en);
	assign full_out = ocnt_q >= MAXS_C;

	assign in_ready = state_q == S_COLL;

	always_comb begin
		out_tok = '0;
		out_valid = 1'b0;
		case (state_q)
			S_EMITX: begin
				out_valid = !full_out;
				out_tok.has_vtx = 1'b1;
				out_tok.x = ON_Y ? cross_q : edge_val;
				out_tok.y = ON_Y ? edge_val : cross_q;
			end
			S_EMITC: begin
				out_valid = !full_out;
				out_tok.has_vtx = 1'b1;
				out_tok.x = cur_x_q;
				out_tok.y = cur_y_q;
			end
			S_END: begin
				out_valid = 1'b1;
				out_tok.eop = 1'b1;
				out_tok.ovf = ovf_q;
			end
			default: begin
				out_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[cnt_q[AW-1:0]] <= {in_tok.x, in_tok.y};
		end
		rdata_q <= mem[idx_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_COLL;
			cnt_q <= '0;
			idx_q <= '0;
			ocnt_q <= '0;
			ovf_q <= 1'b0;
			step_q <= '0;
		end else begin
			case (state_q)
				S_COLL: begin
					if (in_valid) begin
						cnt_q <= cnt_n;
						ovf_q <= ovf_q | in_tok.ovf | (in_tok.has_vtx && !room);
						if (in_tok.eop) begin
							if (cnt_n == '0) begin
								state_q <= S_END;
							end else begin
								idx_q <= cnt_n - CNTW'(1);
								state_q <= S_RPREV;
							end
						end
					end
				end
				S_RPREV: begin
					idx_q <= '0;
					state_q <= S_LPREV;
				end
				S_LPREV: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					if (pin != cin) begin
						if (dc == '0) begin
							state_q <= S_EMITX;
						end else begin
							state_q <= S_MUL;
						end
					end else if (cin) begin
						state_q <= S_EMITC;
					end else begin
						state_q <= S_ADV;
					end
				end
				S_MUL: begin
					step_q <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					step_q <= step_q + SW'(1);
					if (step_q == LAST_STEP_C) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					state_q <= S_EMITX;
				end
				S_EMITX: begin
					if (full_out) begin
						ovf_q <= 1'b1;
						state_q <= cin_q ? S_EMITC : S_ADV;
					end else if (out_ready) begin
						ocnt_q <= ocnt_q + OCW'(1);
						state_q <= cin_q ? S_EMITC : S_ADV;
					end
				end
				S_EMITC: begin
					if (full_out) begin
						ovf_q <= 1'b1;
						state_q <= S_ADV;
					end else if (out_ready) begin
						ocnt_q <= ocnt_q + OCW'(1);
						state_q <= S_ADV;
					end
				end
				S_ADV: begin
					if (idx_q + CNTW'(1) == cnt_q) begin
						state_q <= S_END;
					end else begin
						idx_q <= idx_q + CNTW'(1);
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					state_q <= S_EVAL;
				end
				S_END: begin
					if (out_ready) begin
						cnt_q <= '0;
						ocnt_q <= '0;
						ovf_q <= 1'b0;
						state_q <= S_COLL;
					end
				end
				default: begin
					state_q <= S_COLL;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_LPREV: begin
				prev_x_q <= rd_x;
				prev_y_q <= rd_y;
			end
			S_EVAL: begin
				cur_x_q <= rd_x;
				cur_y_q <= rd_y;
				cin_q <= cin;
				mag_a_q <= da[CW] ? CW'(1) + (CW+1)'(~da) : da;
				mag_b_q <= db[CW] ? CW'(1) + (CW+1)'(~db) : db;
				mag_c_q <= dc[CW] ? CW'(1) + (CW+1)'(~dc) : dc;
				neg_q <= da[CW] ^ db[CW] ^ dc[CW];
				cross_q <= co;
			end
			S_MUL: begin
				prod_q <= mag_a_q * mag_b_q;
				rem_q <= '0;
			end
			S_DIV: begin
				prod_q <= {prod_q[PW-2:0], qbit};
				rem_q <= qbit ? CW'(0) + (CW+1)'(rem_sh - {1'b0, mag_c_q})
				              : rem_sh[CW:0];
			end
			S_FIN: begin
				cross_q <= clamped;
			end
			S_ADV: begin
				prev_x_q <= cur_x_q;
				prev_y_q <= cur_y_q;
			end
			default: begin
				cross_q <= cross_q;
			end
		endcase
	end

endmodule

/* rtl/core/prc_merge_cell.sv */
// ----------------------------------------------------------------------------
// prc_merge_cell
// Drops consecutive repeated vertices and a closing duplicate and sends the result items.
// ----------------------------------------------------------------------------
module prc_merge_cell #(
	parameter int MAXS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  prc_pkg::token_t    in_tok,
	output logic               out_valid,
	input  logic               out_ready,
	output prc_pkg::out_item_t out_item
);

	localparam int CW = prc_pkg::COORD_W;
	localparam int AW = $clog2(MAXS);
	localparam int KW = $clog2(MAXS + 1);
	localparam logic [KW-1:0] MAXS_C = KW'(MAXS);

	localparam logic [1:0] S_COLL  = 2'd0;
	localparam logic [1:0] S_RD    = 2'd1;
	localparam logic [1:0] S_SHOW  = 2'd2;
	localparam logic [1:0] S_EMPTY = 2'd3;

	logic [1:0]      state_q;
	logic [KW-1:0]   k_q, kf_q, ridx_q, k_n, kf_n;
	logic [2*CW-1:0] mem [MAXS];
	logic [2*CW-1:0] rdata_q, first_q, lastk_q, v, first_n, lastk_n;
	logic            ovf_q, wr_en, is_last;

	assign v = {in_tok.x, in_tok.y};
	assign wr_en = (state_q == S_COLL) && in_valid && in_tok.has_vtx && (k_q < MAXS_C)
		&& ((k_q == '0) || (v != lastk_q));
	assign k_n = k_q + KW'(wr_en);
	assign lastk_n = wr_en ? v : lastk_q;
	assign first_n = (wr_en && (k_q == '0)) ? v : first_q;
	// a last vertex equal to the first closes onto it
	assign kf_n = k_n - KW'((k_n != '0) && (lastk_n == first_n));
	assign is_last = ridx_q == kf_q - KW'(1);

	assign in_ready = state_q == S_COLL;
	assign out_valid = (state_q == S_SHOW) || (state_q == S_EMPTY);

	always_comb begin
		out_item = '0;
		out_item.overflow = ovf_q;
		case (state_q)
			S_SHOW: begin
				out_item.out_x = rdata_q[2*CW-1:CW];
				out_item.out_y = rdata_q[CW-1:0];
				out_item.out_last = is_last;
			end
			S_EMPTY: begin
				out_item.out_last = 1'b1;
				out_item.empty_res = 1'b1;
			end
			default: begin
				out_item.out_last = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[k_q[AW-1:0]] <= v;
		end
		rdata_q <= mem[ridx_q[AW-1:0]];
		if (state_q == S_COLL && in_valid) begin
			first_q <= first_n;
			lastk_q <= lastk_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_COLL;
			k_q <= '0;
			kf_q <= '0;
			ridx_q <= '0;
			ovf_q <= 1'b0;
		end else begin
			case (state_q)
				S_COLL: begin
					if (in_valid) begin
						k_q <= k_n;
						if (in_tok.eop) begin
							ovf_q <= in_tok.ovf;
							kf_q <= kf_n;
							ridx_q <= '0;
							state_q <= (kf_n == '0) ? S_EMPTY : S_RD;
						end
					end
				end
				S_RD: begin
					state_q <= S_SHOW;
				end
				S_SHOW: begin
					if (out_ready) begin
						if (is_last) begin
							k_q <= '0;
							state_q <= S_COLL;
						end else begin
							ridx_q <= ridx_q + KW'(1);
							state_q <= S_RD;
						end
					end
				end
				S_EMPTY: begin
					if (out_ready) begin
						k_q <= '0;
						state_q <= S_COLL;
					end
				end
				default: begin
					state_q <= S_COLL;
				end
			endcase
		end
	end

endmodule

/* rtl/core/polygon_rect_clipper.sv */
// ----------------------------------------------------------------------------
// polygon_rect_clipper
// Clips a polygon against a rectangle through a chain of four clip cells.
// ----------------------------------------------------------------------------
// usage:
//  - vertices arrive on vtx_valid/vtx_ready/vtx_item, one per transfer;
//    last_vertex on a transfer closes the polygon and starts the clip
//  - results leave on res_valid/res_ready/res_item; out_last marks the final
//    one, an empty clip gives a single item with empty_res set
//  - boundaries are written through cfg_we/cfg_index/cfg_data while idle
//  - plain vertices are accepted back to back; after a closing vertex the
//    input stalls until the first cell has walked the polygon
//  - each cell walks its polygon vertex by vertex through evaluate, emit,
//    advance and wait steps; an edge crossing adds a multiply, a bit-serial
//    divide and a clamp before the crossing point is emitted
//  - the merge cell reads each result item from its store, then shows it
//  - the four cells and the merge cell work on consecutive polygons at once
//  - reset clears all control state and the boundaries to zero; no clearing
//    pass is needed
//  - a stalled receiver backs up through the merge cell and the clip chain
//    to the input without losing any vertex
// ----------------------------------------------------------------------------
module polygon_rect_clipper #(
	parameter int MAX_IN_VERTICES = 8,
	parameter int MAX_STAGE_VERTICES = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              vtx_valid,
	output logic                              vtx_ready,
	input  prc_pkg::in_item_t                 vtx_item,
	output logic                              res_valid,
	input  logic                              res_ready,
	output prc_pkg::out_item_t                res_item,
	input  logic                              cfg_we,
	input  logic [prc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [prc_pkg::COORD_W-1:0]       cfg_data
);

	// clip boundaries
	prc_pkg::coord_t left_q, right_q, top_q, bottom_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			right_q <= '0;
			top_q <= '0;
			bottom_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				prc_pkg::REG_LEFT:   left_q <= cfg_data;
				prc_pkg::REG_RIGHT:  right_q <= cfg_data;
				prc_pkg::REG_TOP:    top_q <= cfg_data;
				prc_pkg::REG_BOTTOM: bottom_q <= cfg_data;
				default: begin
					// writes beyond the register list are dropped
					left_q <= left_q;
				end
			endcase
		end
	end

	// input vertex as a stream token
	prc_pkg::token_t in_tok;
	always_comb begin
		in_tok.x = vtx_item.vertex_x;
		in_tok.y = vtx_item.vertex_y;
		in_tok.has_vtx = 1'b1;
		in_tok.eop = vtx_item.last_vertex;
		in_tok.ovf = 1'b0;
	end

	prc_pkg::token_t tok1, tok2, tok3, tok4;
	logic v1, r1, v2, r2, v3, r3, v4, r4;

	// left pass: its vertex store doubles as the input store
	prc_clip_cell #(
		.DEPTH(MAX_IN_VERTICES), .MAXS(MAX_STAGE_VERTICES), .ON_Y(1'b0), .KEEP_GE(1'b1)
	) u_left (
		.clk(clk), .arst_n(arst_n), .edge_val(left_q),
		.in_valid(vtx_valid), .in_ready(vtx_ready), .in_tok(in_tok),
		.out_valid(v1), .out_ready(r1), .out_tok(tok1)
	);

	// right pass
	prc_clip_cell #(
		.DEPTH(MAX_STAGE_VERTICES), .MAXS(MAX_STAGE_VERTICES), .ON_Y(1'b0), .KEEP_GE(1'b0)
	) u_right (
		.clk(clk), .arst_n(arst_n), .edge_val(right_q),
		.in_valid(v1), .in_ready(r1), .in_tok(tok1),
		.out_valid(v2), .out_ready(r2), .out_tok(tok2)
	);

	// top pass
	prc_clip_cell #(
		.DEPTH(MAX_STAGE_VERTICES), .MAXS(MAX_STAGE_VERTICES), .ON_Y(1'b1), .KEEP_GE(1'b1)
	) u_top (
		.clk(clk), .arst_n(arst_n), .edge_val(top_q),
		.in_valid(v2), .in_ready(r2), .in_tok(tok2),
		.out_valid(v3), .out_ready(r3), .out_tok(tok3)
	);

	// bottom pass
	prc_clip_cell #(
		.DEPTH(MAX_STAGE_VERTICES), .MAXS(MAX_STAGE_VERTICES), .ON_Y(1'b1), .KEEP_GE(1'b0)
	) u_bottom (
		.clk(clk), .arst_n(arst_n), .edge_val(bottom_q),
		.in_valid(v3), .in_ready(r3), .in_tok(tok3),
		.out_valid(v4), .out_ready(r4), .out_tok(tok4)
	);

	// duplicate removal and result transfer
	prc_merge_cell #(
		.MAXS(MAX_STAGE_VERTICES)
	) u_merge (
		.clk(clk), .arst_n(arst_n),
		.in_valid(v4), .in_ready(r4), .in_tok(tok4),
		.out_valid(res_valid), .out_ready(res_ready), .out_item(res_item)
	);

endmodule

/* rtl/core/prc_checker.sv */
// ----------------------------------------------------------------------------
// prc_checker
// Port-level checks of the polygon rectangle clipper.
// ----------------------------------------------------------------------------
module prc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               vtx_valid,
	input logic               vtx_ready,
	input prc_pkg::in_item_t  vtx_item,
	input logic               res_valid,
	input logic               res_ready,
	input prc_pkg::out_item_t res_item
);

	// an empty clip is a single final item
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.empty_res |-> res_item.out_last)
		else $error("empty result without out_last");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.empty_res |-> res_item.out_x == '0 && res_item.out_y == '0)
		else $error("empty result with nonzero coordinates");

	// a closing vertex hands the polygon to the first clip pass
	a_close_stall: assert property (@(posedge clk) disable iff (!arst_n)
		vtx_valid && vtx_ready && vtx_item.last_vertex |=> !vtx_ready)
		else $error("input not held after closing vertex");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_item))
		else $error("result changed while stalled");

endmodule

bind polygon_rect_clipper prc_checker u_prc_checker (
	.clk(clk), .arst_n(arst_n),
	.vtx_valid(vtx_valid), .vtx_ready(vtx_ready), .vtx_item(vtx_item),
	.res_valid(res_valid), .res_ready(res_ready), .res_item(res_item)
);
